/* rtl/core/swls_pkg.sv */
// Shared widths, depths and saturation limits for the sliding window length statistics unit.
package swls_pkg;

  localparam int WIN_DEPTH  = 256;
  localparam int PTR_W      = 8;
  localparam int CNT_W      = 9;
  localparam int LEN_W      = 16;
  localparam int Q8_W       = 24;
  localparam int TREND_W    = 16;
  localparam int SUM_W      = 24;
  localparam int P2_W       = 34;
  localparam int ACC_W      = 56;
  localparam int DIV_NUM_W  = 72;
  localparam int DIV_DEN_W  = 40;
  localparam int DIV_CNT_W  = 7;
  localparam int ROOT_W     = 36;
  localparam int ROOT_CNT_W = 6;
  localparam int EMA_W      = 32;
  localparam int EMA_NUM_W  = 36;
  localparam int OUT_W      = 136;

  localparam logic [Q8_W-1:0] SAT_Q8 = '1;

endpackage

/* rtl/core/swls_ram.sv */
// Single-port-write, registered-read RAM that holds the sample window.
module swls_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/swls_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module swls_div
  import swls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_NUM_W-1:0] quot,
  output logic                 done
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] work;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;

  assign trial = {rem, work[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign quot  = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work  <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem  <= ge ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
      work <= {work[DIV_NUM_W-2:0], ge};
    end
  end

endmodule

/* rtl/core/swls_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
module swls_sqrt
  import swls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] radicand,
  output logic [ROOT_W-1:0]    root,
  output logic                 done
);

  logic                  busy;
  logic [ROOT_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0]  rad;
  logic [ROOT_W+1:0]     rem;
  logic [ROOT_W+1:0]     cur;
  logic [ROOT_W+1:0]     trial;
  logic                  ge;

  assign cur   = {rem[ROOT_W-1:0], rad[DIV_NUM_W-1 -: 2]};
  assign trial = {root, 2'b01};
  assign ge    = cur >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ROOT_CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rem  <= ge ? cur - trial : cur;
      root <= {root[ROOT_W-2:0], ge};
      rad  <= {rad[DIV_NUM_W-3:0], 2'b00};
    end
  end

endmodule

/* rtl/core/sliding_window_length_stats_unit.sv */
// Top level: sequencer, window pointers and statistics passes over the sample RAM.
// A clear item goes to ST_DONE directly; a record item with n samples held runs the sum,
// deviation and EMA passes over the window, divisions on the shared divider, a square root
// and divide-by-ten steps, skipping the trend division when n < 2 or the sum is zero.
// Throughput: one item at a time, taken the cycle after the previous result is registered;
// a stalled output holds the unit. Reset (rst, synchronous) empties the window, zeroes stats.
module sliding_window_length_stats_unit
  import swls_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [LEN_W-1:0] s_tdata,   // sample_length
  input  logic [0:0]       s_tuser,   // kind
  output logic             m_tvalid,
  input  logic             m_tready,
  // sample_count, mean_q8, min_length, max_length, deviation_q8, trend_q14,
  // rising, prediction_q8, then zero padding
  output logic [OUT_W-1:0] m_tdata,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata  // window_size
);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_P1    = 4'd1;
  localparam logic [3:0] ST_MEAN  = 4'd2;
  localparam logic [3:0] ST_P2    = 4'd3;
  localparam logic [3:0] ST_VAR   = 4'd4;
  localparam logic [3:0] ST_ROOT  = 4'd5;
  localparam logic [3:0] ST_DEV   = 4'd6;
  localparam logic [3:0] ST_EMA   = 4'd7;
  localparam logic [3:0] ST_TR0   = 4'd8;
  localparam logic [3:0] ST_TR1   = 4'd9;
  localparam logic [3:0] ST_TR2   = 4'd10;
  localparam logic [3:0] ST_PRED0 = 4'd11;
  localparam logic [3:0] ST_PRED1 = 4'd12;
  localparam logic [3:0] ST_DONE  = 4'd13;

  localparam logic [2:0] SUB_LAST_EMA  = 3'd5;
  localparam logic [2:0] SUB_LAST_PRED = 3'd4;

  // Prediction scale is 163840*256 = 2^22 * 10, so the product is shifted and then
  // divided by ten on the same unit the EMA uses.
  localparam logic [17:0] PRED_BASE  = 18'd163840;
  localparam int          PRED_SHIFT = 22;

  logic [3:0] state;
  logic [2:0] sub;
  logic       launched;

  logic [CNT_W-1:0] wsize;
  logic [PTR_W-1:0] oldest;
  logic [CNT_W-1:0] held;
  logic [PTR_W-1:0] idx;

  // Statistics that survive a clear.
  logic [Q8_W-1:0]  mean_h;
  logic [Q8_W-1:0]  dev_h;
  logic [LEN_W-1:0] min_h;
  logic [LEN_W-1:0] max_h;

  // Working registers of the passes.
  logic [SUM_W-1:0]     sum;
  logic [P2_W-1:0]      p2;
  logic [ACC_W-1:0]     acc;
  logic [SUM_W-1:0]     nx;
  logic [2*SUM_W-1:0]   sq;
  logic [EMA_W-1:0]     ema;
  logic [EMA_NUM_W-1:0] d10_num;
  logic [EMA_NUM_W-1:0] d10_q;
  logic [3:0]           d10_rem;
  logic [15:0]          nn1;
  logic [SUM_W+7:0]     qv;
  logic [P2_W-1:0]      mag;
  logic                 pos;
  logic [DIV_DEN_W-1:0] den_t;
  logic [49:0]          prod;

  logic [TREND_W-1:0] trend;
  logic               rising;
  logic [Q8_W-1:0]    pred;

  // Record bookkeeping: append, then trim to the effective window size.
  logic             full;
  logic [PTR_W-1:0] wr_addr;
  logic [CNT_W-1:0] cnt1;
  logic [PTR_W-1:0] old1;
  logic [CNT_W-1:0] weff;
  logic             rec_fire;

  assign full    = held == CNT_W'(WIN_DEPTH);
  assign wr_addr = full ? oldest : oldest + held[PTR_W-1:0];
  assign cnt1    = full ? held : held + 1'b1;
  assign old1    = full ? oldest + 1'b1 : oldest;
  assign weff    = (wsize == '0) ? CNT_W'(1) :
                   (wsize > CNT_W'(WIN_DEPTH)) ? CNT_W'(WIN_DEPTH) : wsize;

  assign s_tready = state == ST_IDLE;
  assign rec_fire = s_tvalid && s_tready && !s_tuser[0];

  // Sample RAM; reads are issued at sub-step 0 and land in the next cycle.
  logic [PTR_W-1:0] rd_addr;
  logic [LEN_W-1:0] x;

  assign rd_addr = oldest + idx;

  swls_ram #(
    .DEPTH (WIN_DEPTH),
    .WIDTH (LEN_W),
    .ADDR_W(PTR_W)
  ) u_ram (
    .clk  (clk),
    .we   (rec_fire),
    .waddr(wr_addr),
    .wdata(s_tdata),
    .raddr(rd_addr),
    .rdata(x)
  );

  logic last_idx;
  assign last_idx = idx == PTR_W'(held - 1'b1);

  // Shared divider and the square root unit.
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quot;
  logic                 div_done;
  logic                 sqrt_start;
  logic [ROOT_W-1:0]    root;
  logic                 sqrt_done;

  always_comb begin
    div_num = '0;
    div_den = DIV_DEN_W'(held);
    case (state)
      ST_MEAN: div_num = DIV_NUM_W'({sum, 8'd0});
      ST_VAR:  div_num = {acc, 16'd0};
      ST_DEV:  div_num = DIV_NUM_W'(root);
      ST_TR2: begin
        div_num = DIV_NUM_W'({({3'd0, mag} << 2) + ({3'd0, mag} << 1), 14'd0});
        div_den = den_t;
      end
      default: div_num = '0;
    endcase
  end

  assign div_start  = !launched && (state == ST_MEAN || state == ST_VAR ||
                                    state == ST_DEV || state == ST_TR2);
  assign sqrt_start = !launched && state == ST_ROOT;

  swls_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .quot (div_quot),
    .done (div_done)
  );

  swls_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .radicand(div_quot),
    .root    (root),
    .done    (sqrt_done)
  );

  // Divide-by-ten for the EMA and the prediction: nine quotient bits per cycle across the
  // 36-bit numerator.
  logic [3:0]           d10_rem_next;
  logic [EMA_NUM_W-1:0] d10_num_next;
  logic [EMA_NUM_W-1:0] d10_q_next;
  logic [4:0]           d10_t;

  always_comb begin
    d10_rem_next = d10_rem;
    d10_num_next = d10_num;
    d10_q_next   = d10_q;
    d10_t        = '0;
    for (int k = 0; k < 9; k++) begin
      d10_t        = {d10_rem_next, d10_num_next[EMA_NUM_W-1]};
      d10_num_next = {d10_num_next[EMA_NUM_W-2:0], 1'b0};
      if (d10_t >= 5'd10) begin
        d10_rem_next = 4'(d10_t - 5'd10);
        d10_q_next   = {d10_q_next[EMA_NUM_W-2:0], 1'b1};
      end else begin
        d10_rem_next = d10_t[3:0];
        d10_q_next   = {d10_q_next[EMA_NUM_W-2:0], 1'b0};
      end
    end
  end

  // EMA numerator: 3*(x<<16) + 7*previous, seeded from the oldest sample.
  logic [EMA_NUM_W-1:0] xs;
  logic [EMA_NUM_W-1:0] es;
  logic [EMA_NUM_W-1:0] ema_num;

  assign xs      = EMA_NUM_W'({x, 16'd0});
  assign es      = (idx == '0) ? xs : EMA_NUM_W'(ema);
  assign ema_num = (xs << 1) + xs + (es << 3) - es;

  // Deviation term |n*x - S| feeds the squarer.
  logic [SUM_W-1:0] dabs;
  assign dabs = (nx >= sum) ? nx - sum : sum - nx;

  // Trend helpers.
  logic [P2_W-1:0]  qv_w;
  logic [40:0]      mag60;
  logic [18:0]      pred_fac;
  logic             trend_ok;

  assign qv_w     = P2_W'(qv);
  assign mag60    = 41'({mag, 6'd0} - {mag, 2'd0});
  assign pred_fac = 19'(PRED_BASE) + {{3{trend[TREND_W-1]}}, trend};
  assign trend_ok = held >= CNT_W'(2) && sum != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sub      <= '0;
      launched <= 1'b0;
      wsize    <= CNT_W'(WIN_DEPTH);
      oldest   <= '0;
      held     <= '0;
      idx      <= '0;
      mean_h   <= '0;
      dev_h    <= '0;
      min_h    <= '0;
      max_h    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        wsize <= cfg_wdata;
      end
      // The result register is reloaded from ST_DONE in the same cycle it drains.
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            idx <= '0;
            sub <= '0;
            if (s_tuser[0]) begin
              held   <= '0;
              oldest <= '0;
              trend  <= '0;
              rising <= 1'b0;
              pred   <= '0;
              state  <= ST_DONE;
            end else begin
              if (cnt1 > weff) begin
                held   <= weff;
                oldest <= old1 + PTR_W'(cnt1 - weff);
              end else begin
                held   <= cnt1;
                oldest <= old1;
              end
              sum   <= '0;
              p2    <= '0;
              acc   <= '0;
              state <= ST_P1;
            end
          end
        end

        // Sum, index-weighted sum, min and max.
        ST_P1: begin
          if (sub == '0) begin
            sub <= 3'd1;
          end else begin
            sum <= sum + SUM_W'(x);
            p2  <= p2 + P2_W'({SUM_W'(idx) * SUM_W'(x), 1'b0});
            if (idx == '0 || x < min_h) min_h <= x;
            if (idx == '0 || x > max_h) max_h <= x;
            sub <= '0;
            if (last_idx) begin
              idx   <= '0;
              state <= ST_MEAN;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end

        ST_MEAN: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (div_done) begin
            launched <= 1'b0;
            mean_h   <= (div_quot > DIV_NUM_W'(SAT_Q8)) ? SAT_Q8 : div_quot[Q8_W-1:0];
            state    <= ST_P2;
          end
        end

        // Sum of squared deviations, scaled by n squared.
        ST_P2: begin
          case (sub)
            3'd0: sub <= 3'd1;
            3'd1: begin
              nx  <= SUM_W'(held * x);
              sub <= 3'd2;
            end
            3'd2: begin
              sq  <= dabs * dabs;
              sub <= 3'd3;
            end
            default: begin
              acc <= acc + ACC_W'(sq);
              sub <= '0;
              if (last_idx) begin
                idx   <= '0;
                state <= ST_VAR;
              end else begin
                idx <= idx + 1'b1;
              end
            end
          endcase
        end

        ST_VAR: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (div_done) begin
            launched <= 1'b0;
            state    <= ST_ROOT;
          end
        end

        ST_ROOT: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (sqrt_done) begin
            launched <= 1'b0;
            state    <= ST_DEV;
          end
        end

        ST_DEV: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (div_done) begin
            launched <= 1'b0;
            dev_h    <= (div_quot > DIV_NUM_W'(SAT_Q8)) ? SAT_Q8 : div_quot[Q8_W-1:0];
            state    <= ST_EMA;
          end
        end

        // EMA walk: read, form numerator, then divide it by ten.
        ST_EMA: begin
          case (sub)
            3'd0: sub <= 3'd1;
            3'd1: begin
              d10_num <= ema_num;
              d10_rem <= '0;
              sub     <= 3'd2;
            end
            default: begin
              d10_num <= d10_num_next;
              d10_rem <= d10_rem_next;
              d10_q   <= d10_q_next;
              if (sub == SUB_LAST_EMA) begin
                ema <= d10_q_next[EMA_W-1:0];
                sub <= '0;
                if (last_idx) begin
                  idx   <= '0;
                  state <= ST_TR0;
                end else begin
                  idx <= idx + 1'b1;
                end
              end else begin
                sub <= sub + 1'b1;
              end
            end
          endcase
        end

        ST_TR0: begin
          trend  <= '0;
          rising <= 1'b0;
          if (trend_ok) begin
            nn1   <= 16'(held * held - 1'b1);
            qv    <= (SUM_W + 8)'((held - 1'b1) * sum);
            state <= ST_TR1;
          end else begin
            state <= ST_PRED0;
          end
        end

        ST_TR1: begin
          pos   <= p2 >= qv_w;
          mag   <= (p2 >= qv_w) ? p2 - qv_w : qv_w - p2;
          den_t <= nn1 * sum;
          state <= ST_TR2;
        end

        ST_TR2: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (div_done) begin
            launched <= 1'b0;
            if (pos) begin
              trend  <= (div_quot > DIV_NUM_W'(32767)) ? 16'sh7FFF : div_quot[TREND_W-1:0];
              rising <= {1'b0, den_t} < mag60;
            end else begin
              trend  <= (div_quot > DIV_NUM_W'(32768)) ? 16'h8000 :
                        TREND_W'(-div_quot[TREND_W-1:0]);
            end
            state <= ST_PRED0;
          end
        end

        ST_PRED0: begin
          prod  <= ema * pred_fac[17:0];
          state <= ST_PRED1;
        end

        // Load the shifted product, then divide it by ten.
        ST_PRED1: begin
          if (sub == '0) begin
            d10_num <= EMA_NUM_W'(prod[49:PRED_SHIFT]);
            d10_rem <= '0;
            sub     <= 3'd1;
          end else begin
            d10_num <= d10_num_next;
            d10_rem <= d10_rem_next;
            d10_q   <= d10_q_next;
            if (sub == SUB_LAST_PRED) begin
              pred  <= (d10_q_next > EMA_NUM_W'(SAT_Q8)) ? SAT_Q8 : d10_q_next[Q8_W-1:0];
              sub   <= '0;
              state <= ST_DONE;
            end else begin
              sub <= sub + 1'b1;
            end
          end
        end

        // Hand the result to the output register once it is free.
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {6'd0, pred, rising, trend, dev_h, max_h, min_h, mean_h, held};
    end
  end

`ifndef NO_ASSERTIONS
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(WIN_DEPTH))
    else $error("window count exceeds depth");

  a_rising_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[105] || (!m_tdata[104] && m_tdata[104:89] != '0))
    else $error("rising flag without a positive trend");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[8:0] == '0) |-> (m_tdata[129:89] == '0))
    else $error("empty window reports trend or prediction");

  a_minmax: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[8:0] != '0) |-> (m_tdata[48:33] <= m_tdata[64:49]))
    else $error("min above max");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(div_start && sqrt_start))
    else $error("divider and root started together");
`endif

endmodule
